// ===== hw/rtl/bitmap_text_block_generator_defines.svh =====
// Assertion macros for the bitmap text block generator RTL
`ifndef BITMAP_TEXT_BLOCK_GENERATOR_DEFINES_SVH
`define BITMAP_TEXT_BLOCK_GENERATOR_DEFINES_SVH

// plain property, checked at every edge out of reset
`define BTBG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BTBG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTBG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/btbg_pkg.sv =====
// Package with font ROM, glyph lookup and shared types of the text block generator
`timescale 1ns / 1ps
`default_nettype none
package btbg_pkg;

  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_CELLS   = GLYPH_ROWS * GLYPH_COLS;
  localparam int NUM_GLYPHS    = 43;
  localparam int GLYPH_IDX_W   = 6;
  localparam int SCALE_W       = 4;
  localparam int CODE_W        = 8;
  localparam int COL_W         = 3;

  localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [SCALE_W-1:0] SCALE_MIN    = 4'd1;
  localparam logic [SCALE_W-1:0] SCALE_MAX    = 4'd8;
  localparam logic [COL_W-1:0]   COL_LAST     = 3'(GLYPH_COLS - 1);

  localparam logic [GLYPH_IDX_W-1:0] GLYPH_DIGIT0 = 6'd0;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_LETTER = 6'd10;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_BANG   = 6'd36;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_QUERY  = 6'd37;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_DASH   = 6'd38;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_DOT    = 6'd39;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_COLON  = 6'd40;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_GT     = 6'd41;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_LT     = 6'd42;

  localparam logic [CODE_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CODE_W-1:0] CH_QUERY = 8'h3f;
  localparam logic [CODE_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [CODE_W-1:0] CH_UNDER = 8'h5f;
  localparam logic [CODE_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CODE_W-1:0] CH_COLON = 8'h3a;
  localparam logic [CODE_W-1:0] CH_GT    = 8'h3e;
  localparam logic [CODE_W-1:0] CH_LT    = 8'h3c;
  localparam logic [CODE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CODE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CODE_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CODE_W-1:0] CH_UC_Z  = 8'h5a;
  localparam logic [CODE_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CODE_W-1:0] CH_LC_Z  = 8'h7a;
  localparam logic [CODE_W-1:0] CASE_GAP = 8'h20;

  typedef logic [GLYPH_IDX_W-1:0] glyph_idx_t;
  typedef logic [GLYPH_CELLS-1:0] glyph_mask_t;
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] font_glyph_t;

  typedef struct packed {
    logic       known;
    glyph_idx_t idx;
  } glyph_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_e;

  localparam font_glyph_t FONT_ROM [NUM_GLYPHS] = '{
    {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e},
    {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
    {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
    {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e},
    {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
    {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e},
    {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
    {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
    {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e},
    {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
    {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e},
    {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e},
    {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e},
    {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f},
    {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10},
    {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f},
    {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
    {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
    {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c},
    {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f},
    {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
    {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10},
    {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d},
    {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11},
    {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e},
    {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1b, 5'h11},
    {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11},
    {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f},
    {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04},
    {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04},
    {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c},
    {5'h00, 5'h0c, 5'h0c, 5'h00, 5'h0c, 5'h0c, 5'h00},
    {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10},
    {5'h01, 5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 5'h01}
  };

  function automatic glyph_sel_t glyph_lookup(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] c;
    glyph_sel_t        r;
    c = code;
    if (c >= CH_LC_A && c <= CH_LC_Z) begin
      c = c - CASE_GAP;
    end
    r.known = 1'b1;
    r.idx   = GLYPH_DIGIT0;
    priority if (c >= CH_ZERO && c <= CH_NINE) begin
      r.idx = GLYPH_IDX_W'(c - CH_ZERO);
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      r.idx = GLYPH_IDX_W'(c - CH_UC_A) + GLYPH_LETTER;
    end else begin
      unique case (c)
        CH_BANG:          r.idx = GLYPH_BANG;
        CH_QUERY:         r.idx = GLYPH_QUERY;
        CH_DASH, CH_UNDER: r.idx = GLYPH_DASH;
        CH_DOT:           r.idx = GLYPH_DOT;
        CH_COLON:         r.idx = GLYPH_COLON;
        CH_GT:            r.idx = GLYPH_GT;
        CH_LT:            r.idx = GLYPH_LT;
        default:          r.known = 1'b0;
      endcase
    end
    return r;
  endfunction

  // bit row*GLYPH_COLS+col is the cell at that row and column
  function automatic glyph_mask_t glyph_mask(input glyph_idx_t idx);
    font_glyph_t g;
    glyph_mask_t m;
    g = '0;
    if (32'(idx) < NUM_GLYPHS) begin
      g = FONT_ROM[idx];
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        m[r*GLYPH_COLS+c] = g[r][GLYPH_COLS-1-c];
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/btbg_front.sv =====
// Front end: accepts characters, tracks the pen and queues glyph requests
`timescale 1ns / 1ps
`default_nettype none
module btbg_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [btbg_pkg::CODE_W-1:0]          char_code_i,
  input  logic                                 first_i,
  input  logic [COORD_BITS-1:0]                origin_x_i,
  input  logic [COORD_BITS-1:0]                origin_y_i,
  input  logic [btbg_pkg::SCALE_W-1:0]         glyph_scale_i,
  output logic                                 push_valid_o,
  output logic [2*COORD_BITS+btbg_pkg::SCALE_W+btbg_pkg::GLYPH_IDX_W-1:0] push_data_o,
  input  logic                                 queue_full_i
);

  localparam int AccW = COORD_BITS + 1;

  logic [COORD_BITS-1:0]        pen_x_q, pen_x_d;
  logic [COORD_BITS-1:0]        pen_y_q, pen_y_d;
  logic [COORD_BITS-1:0]        line_x_q, line_x_d;
  logic [btbg_pkg::SCALE_W-1:0] scale_q, scale_d;

  logic                         accept;
  logic                         is_newline;
  btbg_pkg::glyph_sel_t         sel;
  logic [COORD_BITS-1:0]        cur_x, cur_y, cur_line;
  logic [btbg_pkg::SCALE_W-1:0] cur_scale, in_scale;
  logic [AccW-1:0]              adv_sum, feed_sum;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [AccW-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v[AccW-1] != v[AccW-2]) begin
      r = v[AccW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign is_newline = char_code_i == btbg_pkg::NEWLINE_CODE;
  assign sel        = btbg_pkg::glyph_lookup(char_code_i);

  always_comb begin
    priority if (glyph_scale_i < btbg_pkg::SCALE_MIN) begin
      in_scale = btbg_pkg::SCALE_MIN;
    end else if (glyph_scale_i > btbg_pkg::SCALE_MAX) begin
      in_scale = btbg_pkg::SCALE_MAX;
    end else begin
      in_scale = glyph_scale_i;
    end
  end

  always_comb begin
    cur_x     = first_i ? origin_x_i : pen_x_q;
    cur_y     = first_i ? origin_y_i : pen_y_q;
    cur_line  = first_i ? origin_x_i : line_x_q;
    cur_scale = first_i ? in_scale : scale_q;
    adv_sum   = {cur_x[COORD_BITS-1], cur_x} + AccW'({cur_scale, 2'b00})
              + AccW'({cur_scale, 1'b0});
    feed_sum  = {cur_y[COORD_BITS-1], cur_y} + AccW'({cur_scale, 3'b000});
  end

  always_comb begin
    pen_x_d  = pen_x_q;
    pen_y_d  = pen_y_q;
    line_x_d = line_x_q;
    scale_d  = scale_q;
    if (accept) begin
      line_x_d = cur_line;
      scale_d  = cur_scale;
      if (is_newline) begin
        pen_x_d = cur_line;
        pen_y_d = sat_coord(feed_sum);
      end else begin
        pen_x_d = sat_coord(adv_sum);
        pen_y_d = cur_y;
      end
    end
  end

  assign push_valid_o = accept && !is_newline && sel.known;
  assign push_data_o  = {sel.idx, cur_scale, cur_y, cur_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q  <= '0;
      pen_y_q  <= '0;
      line_x_q <= '0;
      scale_q  <= btbg_pkg::SCALE_MIN;
    end else begin
      pen_x_q  <= pen_x_d;
      pen_y_q  <= pen_y_d;
      line_x_q <= line_x_d;
      scale_q  <= scale_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/btbg_fifo.sv =====
// Short request queue between front end and block engine
`timescale 1ns / 1ps
`default_nettype none
module btbg_fifo #(
  parameter int DATA_W = 34,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = count_q == CntW'(DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/btbg_back.sv =====
// Block engine: walks the glyph cells and emits one block per lit cell
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_text_block_generator_defines.svh"
module btbg_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  output logic                  pop_o,
  input  logic [2*COORD_BITS+btbg_pkg::SCALE_W+btbg_pkg::GLYPH_IDX_W-1:0] pop_data_i,
  input  logic                  empty_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] block_x_o,
  output logic [COORD_BITS-1:0] block_y_o,
  output logic                  last_o
);

  localparam int AccW   = COORD_BITS + 1;
  localparam int ScaleLo = 2 * COORD_BITS;
  localparam int IdxLo   = ScaleLo + btbg_pkg::SCALE_W;

  btbg_pkg::back_state_e        state_q, state_d;
  btbg_pkg::glyph_mask_t        mask_q, mask_d;
  logic [btbg_pkg::COL_W-1:0]   col_q, col_d;
  logic [AccW-1:0]              x_acc_q, x_acc_d;
  logic [AccW-1:0]              y_acc_q, y_acc_d;
  logic [COORD_BITS-1:0]        base_x_q, base_x_d;
  logic [btbg_pkg::SCALE_W-1:0] scale_q, scale_d;

  logic                         out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]        out_x_q, out_y_q;
  logic                         out_last_q;

  logic                         lit, last_cell, out_free, step;
  logic [COORD_BITS-1:0]        in_x, in_y;
  logic [btbg_pkg::SCALE_W-1:0] in_scale;
  btbg_pkg::glyph_idx_t         in_idx;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [AccW-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v[AccW-1] != v[AccW-2]) begin
      r = v[AccW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign in_x     = pop_data_i[COORD_BITS-1:0];
  assign in_y     = pop_data_i[ScaleLo-1:COORD_BITS];
  assign in_scale = pop_data_i[IdxLo-1:ScaleLo];
  assign in_idx   = pop_data_i[IdxLo+btbg_pkg::GLYPH_IDX_W-1:IdxLo];

  assign lit       = mask_q[0];
  assign last_cell = mask_q[btbg_pkg::GLYPH_CELLS-1:1] == '0;
  assign out_free  = !out_valid_q || out_ready_i;
  assign step      = (state_q == btbg_pkg::ST_RUN) && (!lit || out_free);
  assign pop_o     = (state_q == btbg_pkg::ST_IDLE) && !empty_i;

  always_comb begin
    state_d  = state_q;
    mask_d   = mask_q;
    col_d    = col_q;
    x_acc_d  = x_acc_q;
    y_acc_d  = y_acc_q;
    base_x_d = base_x_q;
    scale_d  = scale_q;
    unique case (state_q)
      btbg_pkg::ST_IDLE: begin
        if (pop_o) begin
          mask_d   = btbg_pkg::glyph_mask(in_idx);
          col_d    = '0;
          x_acc_d  = {in_x[COORD_BITS-1], in_x};
          y_acc_d  = {in_y[COORD_BITS-1], in_y};
          base_x_d = in_x;
          scale_d  = in_scale;
          state_d  = btbg_pkg::ST_RUN;
        end
      end
      btbg_pkg::ST_RUN: begin
        if (step) begin
          mask_d = {1'b0, mask_q[btbg_pkg::GLYPH_CELLS-1:1]};
          if (col_q == btbg_pkg::COL_LAST) begin
            col_d   = '0;
            x_acc_d = {base_x_q[COORD_BITS-1], base_x_q};
            y_acc_d = y_acc_q + AccW'(scale_q);
          end else begin
            col_d   = col_q + 1'b1;
            x_acc_d = x_acc_q + AccW'(scale_q);
          end
          if (last_cell) begin
            state_d = btbg_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = btbg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && lit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btbg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      col_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q   <= mask_d;
    x_acc_q  <= x_acc_d;
    y_acc_q  <= y_acc_d;
    base_x_q <= base_x_d;
    scale_q  <= scale_d;
    if (step && lit) begin
      out_x_q    <= sat_coord(x_acc_q);
      out_y_q    <= sat_coord(y_acc_q);
      out_last_q <= last_cell;
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_x_o   = out_x_q;
  assign block_y_o   = out_y_q;
  assign last_o      = out_last_q;

  `BTBG_ASSERT_IMPL(a_run_has_cells, state_q == btbg_pkg::ST_RUN, mask_q != '0,
                    "glyph walk with no cells left")
  `BTBG_ASSERT_NXT(a_last_ends_walk, step && lit && last_cell,
                   state_q == btbg_pkg::ST_IDLE && out_last_q,
                   "final block did not end the glyph")
  `BTBG_ASSERT(a_col_in_range, col_q <= btbg_pkg::COL_LAST, "column counter beyond glyph width")

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_text_block_generator.sv =====
// Top level of the bitmap text block generator: front end, request queue and block engine
// A glyph request is written to the two-entry queue when its character is taken; the block
// engine pops it only while idle and then steps through the glyph cells in order up to the
// last lit one (at most 35), registering a block for each lit cell and stalling on a lit cell
// while the previous block still waits; newline and unknown codes are taken with no queue entry.
// Reset (asynchronous, active low): pen and line start at 0, cell scale 1, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_text_block_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // char_code[7:0], origin_x, origin_y, glyph_scale[3:0], zero pad
  input  logic [((2*COORD_BITS+btbg_pkg::CODE_W+btbg_pkg::SCALE_W+7)/8)*8-1:0] s_axis_tdata,
  // first_of_string
  input  logic                                       s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // block_x, block_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_axis_tdata,
  // last_block
  output logic                                       m_axis_tlast
);

  localparam int EntryW  = 2 * COORD_BITS + btbg_pkg::SCALE_W + btbg_pkg::GLYPH_IDX_W;
  localparam int QDepth  = 2;
  localparam int OutW    = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int XLo     = btbg_pkg::CODE_W;
  localparam int YLo     = XLo + COORD_BITS;
  localparam int SLo     = YLo + COORD_BITS;

  logic              push_valid, queue_full, pop, queue_empty;
  logic [EntryW-1:0] push_data, pop_data;
  logic [COORD_BITS-1:0] block_x, block_y;

  btbg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .char_code_i   (s_axis_tdata[btbg_pkg::CODE_W-1:0]),
    .first_i       (s_axis_tuser),
    .origin_x_i    (s_axis_tdata[YLo-1:XLo]),
    .origin_y_i    (s_axis_tdata[SLo-1:YLo]),
    .glyph_scale_i (s_axis_tdata[SLo+btbg_pkg::SCALE_W-1:SLo]),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data),
    .queue_full_i  (queue_full)
  );

  btbg_fifo #(
    .DATA_W(EntryW),
    .DEPTH (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (queue_empty)
  );

  btbg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .empty_i     (queue_empty),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .block_x_o   (block_x),
    .block_y_o   (block_y),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = OutW'({block_y, block_x});

endmodule
`default_nettype wire
